@@ sv/tppm_pkg.sv @@
package tppm_pkg;

    // Width of the capture-tick counter; the count saturates at all ones
    localparam int unsigned PERIOD_WIDTH = 32;

    // Fixed field widths
    localparam int unsigned TICK_WIDTH   = 16;
    localparam int unsigned OUT_WIDTH    = 32;
    localparam int unsigned CFG_IDX_W    = 2;

    typedef logic [PERIOD_WIDTH-1:0] t_period;
    typedef logic [TICK_WIDTH-1:0]   t_ticks;
    typedef logic [1:0]              t_step;
    typedef logic [1:0]              t_phase;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // Sequencer steps (the unused code behaves as holdoff)
    localparam t_step STEP_HOLDOFF = 2'd0;
    localparam t_step STEP_FIRST   = 2'd1;
    localparam t_step STEP_SECOND  = 2'd2;

    // Phase numbers
    localparam t_phase PHASE_ONE   = 2'd1;
    localparam t_phase PHASE_TWO   = 2'd2;
    localparam t_phase PHASE_THREE = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx REG_TIMEOUT = 2'd0;
    localparam t_cfg_idx REG_HOLDOFF = 2'd1;

    // Register reset values
    localparam t_ticks TIMEOUT_RESET = 16'd100;
    localparam t_ticks HOLDOFF_RESET = 16'd500;

    localparam t_ticks  TICKS_MAX  = '1;
    localparam t_period PERIOD_MAX = '1;

endpackage

@@ sv/three_phase_period_meter_core.sv @@
// Output: a result is registered into the output register as the request that ends a phase is taken.
// Throughput: one input request per cycle; the output register parts the two sides, so a
// request is taken whenever the output register is empty or is being drained that cycle.
// Reset (synchronous, active low): holdoff step, phase two first, current selected,
// counters cleared, timeout 100 and holdoff 500 slow ticks, no result pending.
module three_phase_period_meter_core
    import tppm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,

    // configuration writes
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  t_cfg_idx       i_cfg_index,
    input  logic [15:0]    i_cfg_data,

    // input samples
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_slow_tick,
    input  logic           i_capture_tick,
    input  logic           i_edge_phase_one,
    input  logic           i_edge_phase_two,
    input  logic           i_edge_phase_three,

    // results
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_phase_number,
    output logic           o_measured_voltage,
    output logic [31:0]    o_period_counts,
    output logic           o_timed_out,
    output logic           o_round_done,
    output logic           o_select_level
);

    // configuration
    t_ticks  r_timeout, r_holdoff;

    // sequencer state
    t_step   r_step, n_step;
    t_phase  r_phase, n_phase;
    logic    r_vsel, n_vsel;
    t_ticks  r_wait, n_wait;
    t_period r_elapsed, n_elapsed;

    // result register
    logic    r_out_valid;
    t_phase  r_res_phase;
    logic    r_res_volt;
    logic [OUT_WIDTH-1:0] r_res_period;
    logic    r_res_to, r_res_done, r_res_sel;

    // combinational result
    logic    n_res;
    t_phase  n_res_phase;
    logic    n_res_volt;
    t_period n_res_period;
    logic    n_res_to, n_res_done, n_res_sel;

    logic    in_acc;
    logic    edge_sel;
    logic    meas_step;
    t_ticks  wait_inc;
    t_period elap_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    // Configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_holdoff <= HOLDOFF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                REG_HOLDOFF: r_holdoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge of the phase under measurement
    always_comb begin
        case (r_phase)
            PHASE_ONE: edge_sel = i_edge_phase_one;
            PHASE_TWO: edge_sel = i_edge_phase_two;
            default:   edge_sel = i_edge_phase_three;
        endcase
    end

    assign meas_step = (r_step == STEP_FIRST) || (r_step == STEP_SECOND);

    // Saturating counters
    assign wait_inc = r_wait + t_ticks'(i_slow_tick && (r_wait != TICKS_MAX));
    assign elap_inc = r_elapsed + t_period'((r_step == STEP_SECOND) && i_capture_tick
                                            && (r_elapsed != PERIOD_MAX));

    // Next state and result for one sample
    always_comb begin
        n_step       = r_step;
        n_phase      = r_phase;
        n_vsel       = r_vsel;
        n_wait       = r_wait;
        n_elapsed    = r_elapsed;
        n_res        = 1'b0;
        n_res_phase  = r_phase;
        n_res_volt   = r_vsel;
        n_res_period = '0;
        n_res_to     = 1'b0;
        n_res_done   = (r_phase == PHASE_THREE);
        n_res_sel    = r_vsel;

        if (meas_step) begin
            n_wait    = wait_inc;
            n_elapsed = elap_inc;
            if (wait_inc >= r_timeout) begin
                // timeout wins over a same-cycle edge
                n_res    = 1'b1;
                n_res_to = 1'b1;
            end else if (edge_sel) begin
                if (r_step == STEP_FIRST) begin
                    n_step    = STEP_SECOND;
                    n_wait    = '0;
                    n_elapsed = '0;
                end else begin
                    n_res        = 1'b1;
                    n_res_period = elap_inc;
                end
            end

            // phase finished: advance the sequence
            if (n_res) begin
                n_wait    = '0;
                n_elapsed = '0;
                if (r_phase == PHASE_THREE) begin
                    n_vsel    = !r_vsel;
                    n_res_sel = !r_vsel;
                    n_phase   = PHASE_TWO;
                    n_step    = STEP_HOLDOFF;
                end else begin
                    n_phase = (r_phase == PHASE_TWO) ? PHASE_ONE : PHASE_THREE;
                    n_step  = STEP_FIRST;
                end
            end
        end else begin
            // holdoff (also the unused step code)
            n_step = STEP_HOLDOFF;
            if (i_slow_tick) begin
                if (r_wait >= r_holdoff) begin
                    n_step    = STEP_FIRST;
                    n_wait    = '0;
                    n_elapsed = '0;
                end else begin
                    n_wait = r_wait + t_ticks'(1);
                end
            end
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_HOLDOFF;
            r_phase   <= PHASE_TWO;
            r_vsel    <= 1'b0;
            r_wait    <= '0;
            r_elapsed <= '0;
        end else if (in_acc) begin
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_vsel    <= n_vsel;
            r_wait    <= n_wait;
            r_elapsed <= n_elapsed;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && n_res) begin
            r_res_phase  <= n_res_phase;
            r_res_volt   <= n_res_volt;
            r_res_period <= OUT_WIDTH'(n_res_period);
            r_res_to     <= n_res_to;
            r_res_done   <= n_res_done;
            r_res_sel    <= n_res_sel;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_phase_number     = r_res_phase;
    assign o_measured_voltage = r_res_volt;
    assign o_period_counts    = r_res_period;
    assign o_timed_out        = r_res_to;
    assign o_round_done       = r_res_done;
    assign o_select_level     = r_res_sel;

    // A round ends only on phase three
    a_done_phase3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_done |-> r_res_phase == PHASE_THREE)
        else $error("round done on a phase other than three");

    // A timeout reports a zero count
    a_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_to |-> r_res_period == '0)
        else $error("timeout with nonzero count");

    // Selection after a result toggles exactly when the round ends
    a_sel_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res_sel == (r_res_volt ^ r_res_done))
        else $error("select level inconsistent with round done");

    // Ending a round returns to holdoff on phase two with the new selection
    a_round_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_res && n_res_done |=>
            r_step == STEP_HOLDOFF && r_phase == PHASE_TWO && r_vsel == r_res_sel)
        else $error("sequencer did not restart after round");

    // An empty result register never stalls the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tppm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    // cycles allowed after the last result for any sample still in flight
    localparam int unsigned SETTLE_CYCLES = 8;

    // one sample of the tick and edge pins
    typedef struct packed {
        logic slow;
        logic cap;
        logic e1;
        logic e2;
        logic e3;
    } t_sample;

    // one period measurement as reported by the block
    typedef struct packed {
        t_phase  phase;
        logic    volt;
        t_period period;
        logic    tmo;
        logic    done;
        logic    sel;
    } t_meas;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = REG_TIMEOUT;
    t_ticks      i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_slow_tick = 1'b0;
    logic        i_capture_tick = 1'b0;
    logic        i_edge_phase_one = 1'b0;
    logic        i_edge_phase_two = 1'b0;
    logic        i_edge_phase_three = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_phase_number;
    logic        o_measured_voltage;
    logic [31:0] o_period_counts;
    logic        o_timed_out;
    logic        o_round_done;
    logic        o_select_level;

    three_phase_period_meter_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_slow_tick        (i_slow_tick),
        .i_capture_tick     (i_capture_tick),
        .i_edge_phase_one   (i_edge_phase_one),
        .i_edge_phase_two   (i_edge_phase_two),
        .i_edge_phase_three (i_edge_phase_three),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_phase_number     (o_phase_number),
        .o_measured_voltage (o_measured_voltage),
        .o_period_counts    (o_period_counts),
        .o_timed_out        (o_timed_out),
        .o_round_done       (o_round_done),
        .o_select_level     (o_select_level)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // meter shadow state and register copies
    t_step   mtr_step = STEP_HOLDOFF;
    t_phase  mtr_phase = PHASE_TWO;
    logic    mtr_volt = 1'b0;
    t_ticks  mtr_wait = '0;
    t_period mtr_elapsed = '0;
    t_ticks  cfg_timeout = TIMEOUT_RESET;
    t_ticks  cfg_holdoff = HOLDOFF_RESET;

    t_sample     sample_queue[$];
    t_meas       meas_due[$];
    t_sample     cur_sample;
    t_meas       drv_meas;
    t_meas       due_meas;
    int unsigned samples_queued = 0;
    int unsigned samples_taken = 0;
    int unsigned meas_seen = 0;
    int unsigned timeouts_seen = 0;
    int unsigned rounds_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned errors = 0;
    int unsigned idle_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    bit          src_gaps = 1'b1;
    bit          sink_stalls = 1'b1;

    // close the active phase and advance the sequencer
    function automatic t_meas close_phase(t_period period, logic tmo);
        t_meas m;
        m.phase  = mtr_phase;
        m.volt   = mtr_volt;
        m.period = period;
        m.tmo    = tmo;
        m.done   = (mtr_phase == PHASE_THREE);
        mtr_wait    = '0;
        mtr_elapsed = '0;
        if (m.done) begin
            mtr_volt  = ~mtr_volt;
            mtr_phase = PHASE_TWO;
            mtr_step  = STEP_HOLDOFF;
        end else begin
            mtr_phase = (mtr_phase == PHASE_TWO) ? PHASE_ONE : PHASE_THREE;
            mtr_step  = STEP_FIRST;
        end
        m.sel = mtr_volt;
        return m;
    endfunction

    // advance the meter by one sample; returns 1 when a measurement completes
    function automatic bit step_meter(input t_sample s, output t_meas m);
        logic hit;
        m = '0;
        case (mtr_phase)
            PHASE_ONE: hit = s.e1;
            PHASE_TWO: hit = s.e2;
            default:   hit = s.e3;
        endcase
        if (mtr_step == STEP_FIRST || mtr_step == STEP_SECOND) begin
            if (mtr_step == STEP_SECOND && s.cap && mtr_elapsed != PERIOD_MAX)
                mtr_elapsed = mtr_elapsed + 1'b1;
            if (s.slow && mtr_wait != TICKS_MAX)
                mtr_wait = mtr_wait + 1'b1;
            // timeout beats a same-cycle edge
            if (mtr_wait >= cfg_timeout) begin
                m = close_phase('0, 1'b1);
                return 1'b1;
            end
            if (hit) begin
                if (mtr_step == STEP_FIRST) begin
                    mtr_step    = STEP_SECOND;
                    mtr_wait    = '0;
                    mtr_elapsed = '0;
                    return 1'b0;
                end
                m = close_phase(mtr_elapsed, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        // holdoff, and the spare step code
        mtr_step = STEP_HOLDOFF;
        if (s.slow) begin
            if (mtr_wait >= cfg_holdoff) begin
                mtr_step    = STEP_FIRST;
                mtr_wait    = '0;
                mtr_elapsed = '0;
            end else begin
                mtr_wait = mtr_wait + 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_sample smp(bit slow, bit cap, bit e1, bit e2, bit e3);
        t_sample s;
        s.slow = slow;
        s.cap  = cap;
        s.e1   = e1;
        s.e2   = e2;
        s.e3   = e3;
        return s;
    endfunction

    // random sample with a chosen slow tick and a chosen edge on one phase
    function automatic t_sample make_sample(bit slow, t_phase ph, bit own);
        t_sample s;
        s = t_sample'($urandom_range(0, 31));
        s.slow = slow;
        case (ph)
            PHASE_ONE: s.e1 = own;
            PHASE_TWO: s.e2 = own;
            default:   s.e3 = own;
        endcase
        return s;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add(t_sample s);
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // one register write request; waits for the handshake
    task automatic write_reg(t_cfg_idx idx, t_ticks val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_TIMEOUT)
            cfg_timeout = val;
        else
            cfg_holdoff = val;
        reg_writes++;
    endtask

    // hold the sender until everything has come back, then let the block settle
    task automatic drain();
        while (samples_taken != samples_queued || meas_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one round of samples: holdoff ticks, then phases two, one and three
    task automatic queue_round(int unsigned hold, int unsigned tmo);
        t_phase      order[3];
        int unsigned r;
        order = '{PHASE_TWO, PHASE_ONE, PHASE_THREE};
        repeat ((hold < 12 ? hold : 12) + 1)
            add(make_sample(1'b1, PHASE_TWO, $urandom_range(0, 1)));
        foreach (order[k]) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                // an opening edge and a closing edge with capture ticks in between
                repeat ($urandom_range(0, 2)) add(make_sample(1'b0, order[k], 1'b0));
                add(make_sample(1'b0, order[k], 1'b1));
                repeat ($urandom_range(0, 10))
                    add(make_sample($urandom_range(0, 7) == 0, order[k], 1'b0));
                add(make_sample($urandom_range(0, 3) == 0, order[k], 1'b1));
            end else if (r < 9) begin
                // let the edge wait run out, after a first edge or before it
                if (r == 8)
                    add(make_sample(1'b0, order[k], 1'b1));
                repeat (tmo < 12 ? tmo : 12) add(make_sample(1'b1, order[k], 1'b0));
            end else begin
                repeat (4) add(t_sample'($urandom_range(0, 31)));
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add(t_sample'($urandom_range(0, 31)));
    endtask

    task automatic queue_rounds(int unsigned count);
        int unsigned goal;
        goal = samples_queued + count;
        while (samples_queued < goal)
            queue_round(cfg_holdoff, cfg_timeout);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (step_meter(cur_sample, drv_meas))
                    meas_due.push_back(drv_meas);
                samples_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    cur_sample = sample_queue.pop_front();
                    i_slow_tick        <= cur_sample.slow;
                    i_capture_tick     <= cur_sample.cap;
                    i_edge_phase_one   <= cur_sample.e1;
                    i_edge_phase_two   <= cur_sample.e2;
                    i_edge_phase_three <= cur_sample.e3;
                    i_in_valid         <= 1'b1;
                    if (src_gaps)
                        idle_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (meas_due.size() == 0) begin
                    $error("measurement for phase %0d with none outstanding", o_phase_number);
                    errors++;
                end else begin
                    due_meas = meas_due.pop_front();
                    check_field("phase_number", due_meas.phase, o_phase_number);
                    check_field("measured_voltage", due_meas.volt, o_measured_voltage);
                    check_field("period_counts", due_meas.period, o_period_counts);
                    check_field("timed_out", due_meas.tmo, o_timed_out);
                    check_field("round_done", due_meas.done, o_round_done);
                    check_field("select_level", due_meas.sel, o_select_level);
                    timeouts_seen += due_meas.tmo;
                    rounds_seen += due_meas.done;
                end
                meas_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short timeout, no holdoff
        write_reg(REG_TIMEOUT, 16'd3);
        write_reg(REG_HOLDOFF, 16'd0);
        add(smp(0, 1, 1, 1, 1));  // edges during holdoff
        add(smp(1, 1, 1, 1, 1));  // round start, its edges ignored
        add(smp(0, 1, 1, 0, 1));  // other phases' edges ignored
        add(smp(0, 1, 0, 1, 0));  // first edge, its capture tick not counted
        add(smp(0, 1, 0, 0, 0));
        add(smp(1, 1, 1, 0, 1));
        add(smp(0, 0, 0, 0, 0));
        add(smp(0, 1, 0, 1, 0));  // closing edge, capture tick counted
        add(smp(1, 0, 0, 0, 0));
        add(smp(1, 0, 0, 0, 0));
        add(smp(1, 1, 1, 0, 0));  // timeout and edge together
        add(smp(0, 0, 0, 0, 1));
        add(smp(1, 1, 0, 0, 0));
        add(smp(1, 1, 0, 0, 0));
        add(smp(1, 1, 0, 0, 1));  // timeout in second wait, round ends
        add(smp(0, 0, 0, 1, 0));
        add(smp(1, 0, 0, 1, 0));
        add(smp(0, 0, 0, 1, 0));
        add(smp(0, 0, 0, 1, 0));  // back-to-back edges, zero period
        repeat (4) add(smp(1, 1, 1, 1, 1));
        drain();

        // random rounds over small settings; the middle pass has no idling
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_TIMEOUT, t_ticks'($urandom_range(1, 6)));
            write_reg(REG_HOLDOFF, t_ticks'($urandom_range(0, 8)));
            src_gaps    = (p != 1);
            sink_stalls = (p != 1);
            queue_rounds(50);
            drain();
            queue_rounds(50);
            drain();
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;

        // largest settings
        write_reg(REG_TIMEOUT, TICKS_MAX);
        write_reg(REG_HOLDOFF, TICKS_MAX);
        queue_rounds(60);
        drain();

        // smallest settings
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_HOLDOFF, 16'd0);
        queue_rounds(120);
        drain();

        // moderate timeout, short holdoff
        write_reg(REG_TIMEOUT, t_ticks'($urandom_range(8, 40)));
        write_reg(REG_HOLDOFF, t_ticks'($urandom_range(1, 4)));
        queue_rounds(120);
        drain();

        $display("Ran %0d samples through %0d register writes, %0d measurements checked",
                 samples_taken, reg_writes, meas_seen);
        $display("  of which %0d timed out and %0d closed a round", timeouts_seen, rounds_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ three_phase_period_meter_core.f @@
sv/tppm_pkg.sv
sv/three_phase_period_meter_core.sv
sim/tb_top.sv
